### design/gqvg_pkg.sv
// ----------------------------------------------------------------------------
// gqvg_pkg
// Types and constants shared by the glyph quad vertex generator.
// ----------------------------------------------------------------------------
package gqvg_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_CHAR  = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   // Register select (byte address bit 2)
   localparam logic CSR_SPACE_WIDTH = 1'b0;
   localparam logic CSR_FONT_HEIGHT = 1'b1;

   // Character codes
   localparam logic [7:0] CHAR_BASE  = 8'd32;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_FIRST = 8'd33;
   localparam logic [7:0] CHAR_LAST  = 8'd126;

   // Register reset values
   localparam logic [7:0] SPACE_WIDTH_RESET = 8'd3;
   localparam logic [7:0] FONT_HEIGHT_RESET = 8'd16;

   // Vertex order per quad: TL, BR, BL, TL, TR, BR (bit i is vertex i)
   localparam logic [5:0] VTX_RIGHT_MASK  = 6'b110010;
   localparam logic [5:0] VTX_BOTTOM_MASK = 6'b100110;
   localparam logic [2:0] VTX_LAST        = 3'd5;

   // One glyph table entry
   typedef struct packed {
      logic [7:0]  width;
      logic [15:0] right_u;
      logic [15:0] left_u;
   } glyph_entry_type;

endpackage

### design/glyph_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator
// Turns a character stream into six textured vertices per printable glyph.
// ----------------------------------------------------------------------------
// A drawn character (codes 33..126) produces six vertices, one per cycle on
// the result channel while rsp_tready is high; a following character waits
// for the last vertex to be taken, as there is a single result port. Loads,
// starts, spaces and ignored codes pass the emitter while it is busy; a
// length query yields one result. Items go through an input register, where
// the glyph table is written (loads) or read with registered data
// (characters), and then into the vertex emitter, which owns the pen, line
// top and running length. The glyph table needs no clearing after reset;
// drawing an entry never loaded returns unspecified u and width values.
module glyph_quad_vertex_generator #(
   parameter int GLYPH_COUNT = 95
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: glyph_index[6:0], glyph_left_u[22:7], glyph_right_u[38:23],
   //        glyph_width[46:39], char_code[54:47], start_x[70:55],
   //        start_y[86:71], zero[87]
   input  logic [87:0]  req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]   req_tuser,
   // Response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: vertex_x[15:0], vertex_y[31:16], tex_u[47:32], tex_v[48],
   //        pixel_length[64:49], zero[71:65]
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast,
   // Register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int EW = (AW > 7) ? AW : 7;

   // Request fields
   logic [6:0]  in_glyph_index;
   logic [15:0] in_left_u;
   logic [15:0] in_right_u;
   logic [7:0]  in_width;
   logic [7:0]  in_char_code;
   logic [15:0] in_start_x;
   logic [15:0] in_start_y;

   assign in_glyph_index = req_tdata[6:0];
   assign in_left_u      = req_tdata[22:7];
   assign in_right_u     = req_tdata[38:23];
   assign in_width       = req_tdata[46:39];
   assign in_char_code   = req_tdata[54:47];
   assign in_start_x     = req_tdata[70:55];
   assign in_start_y     = req_tdata[86:71];

   // Configuration registers
   logic [7:0] space_width_ff;
   logic [7:0] font_height_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         space_width_ff <= gqvg_pkg::SPACE_WIDTH_RESET;
         font_height_ff <= gqvg_pkg::FONT_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            gqvg_pkg::CSR_SPACE_WIDTH: space_width_ff <= csr_pwdata[7:0];
            gqvg_pkg::CSR_FONT_HEIGHT: font_height_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (csr_paddr[2])
         gqvg_pkg::CSR_SPACE_WIDTH: csr_prdata = {24'd0, space_width_ff};
         gqvg_pkg::CSR_FONT_HEIGHT: csr_prdata = {24'd0, font_height_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Input register stage
   logic                   s1_valid_ff;
   gqvg_pkg::req_kind_type s1_kind_ff;
   logic [7:0]             s1_code_ff;
   logic [15:0]            s1_start_x_ff;
   logic [15:0]            s1_start_y_ff;
   logic                   s1_emits;
   logic                   s1_printable;
   logic                   s1_adv;
   logic                   req_accept;

   // Glyph table
   gqvg_pkg::glyph_entry_type glyph_mem [GLYPH_COUNT];
   gqvg_pkg::glyph_entry_type glyph_rd_ff;
   logic [EW-1:0]             load_idx_ext;
   logic [EW-1:0]             char_idx_ext;
   logic [7:0]                char_idx;
   logic                      load_in_range;

   assign load_idx_ext  = EW'(in_glyph_index);
   assign char_idx      = in_char_code - gqvg_pkg::CHAR_BASE;
   assign char_idx_ext  = EW'(char_idx[6:0]);
   assign load_in_range = 32'(in_glyph_index) < GLYPH_COUNT;

   // Write loads and read characters at acceptance
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (gqvg_pkg::req_kind_type'(req_tuser) == gqvg_pkg::REQ_LOAD && load_in_range) begin
            glyph_mem[load_idx_ext[AW-1:0]] <= '{width:   in_width,
                                                 right_u: in_right_u,
                                                 left_u:  in_left_u};
         end
         glyph_rd_ff <= glyph_mem[char_idx_ext[AW-1:0]];
      end
   end

   // Emitter state
   logic        em_valid_ff;
   logic        em_query_ff;
   logic [2:0]  em_cnt_ff;
   logic [15:0] em_xl_ff;
   logic [15:0] em_xr_ff;
   logic [15:0] em_yt_ff;
   logic [15:0] em_yb_ff;
   logic [15:0] em_lu_ff;
   logic [15:0] em_ru_ff;
   logic [15:0] em_len_ff;
   logic        em_last;
   logic        rsp_done;

   // Drawing state
   logic [15:0] pen_x_ff;
   logic [15:0] pen_x_in;
   logic [15:0] line_top_ff;
   logic [15:0] line_top_in;
   logic [15:0] adv_total_ff;
   logic [15:0] adv_total_in;
   logic [15:0] glyph_step;

   assign em_last  = em_query_ff || (em_cnt_ff == gqvg_pkg::VTX_LAST);
   assign rsp_done = em_valid_ff && rsp_tready && em_last;

   // Classify the held item
   assign s1_printable = (s1_code_ff >= gqvg_pkg::CHAR_FIRST)
                      && (s1_code_ff <= gqvg_pkg::CHAR_LAST)
                      && ((32'(s1_code_ff) - 32'(gqvg_pkg::CHAR_BASE)) < GLYPH_COUNT);
   assign s1_emits = (s1_kind_ff == gqvg_pkg::REQ_QUERY)
                  || (s1_kind_ff == gqvg_pkg::REQ_CHAR && s1_printable);

   // Items without results never wait for the emitter
   assign s1_adv     = s1_valid_ff && (!s1_emits || !em_valid_ff || rsp_done);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff    <= gqvg_pkg::req_kind_type'(req_tuser);
         s1_code_ff    <= in_char_code;
         s1_start_x_ff <= in_start_x;
         s1_start_y_ff <= in_start_y;
      end
   end

   // Next pen, line top and running length
   assign glyph_step = 16'(glyph_rd_ff.width) + 16'd1;

   always_comb begin
      pen_x_in     = pen_x_ff;
      line_top_in  = line_top_ff;
      adv_total_in = adv_total_ff;
      if (s1_adv) begin
         unique case (s1_kind_ff)
            gqvg_pkg::REQ_START: begin
               pen_x_in     = s1_start_x_ff;
               line_top_in  = s1_start_y_ff;
               adv_total_in = 16'd0;
            end
            gqvg_pkg::REQ_CHAR: begin
               if (s1_code_ff == gqvg_pkg::CHAR_SPACE) begin
                  pen_x_in     = pen_x_ff + 16'(space_width_ff);
                  adv_total_in = adv_total_ff + 16'(space_width_ff);
               end else if (s1_printable) begin
                  pen_x_in     = pen_x_ff + glyph_step;
                  adv_total_in = adv_total_ff + glyph_step;
               end
            end
            gqvg_pkg::REQ_LOAD, gqvg_pkg::REQ_QUERY: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= 16'd0;
         line_top_ff  <= 16'd0;
         adv_total_ff <= 16'd0;
      end else begin
         pen_x_ff     <= pen_x_in;
         line_top_ff  <= line_top_in;
         adv_total_ff <= adv_total_in;
      end
   end

   // Emitter control: load a new quad or query, step vertices, drain
   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_cnt_ff   <= 3'd0;
      end else if (s1_adv && s1_emits) begin
         em_valid_ff <= 1'b1;
         em_cnt_ff   <= 3'd0;
      end else if (rsp_done) begin
         em_valid_ff <= 1'b0;
      end else if (em_valid_ff && rsp_tready) begin
         em_cnt_ff <= em_cnt_ff + 3'd1;
      end
   end

   // Capture quad corners and texture u for the new item
   always_ff @(posedge clock) begin
      if (s1_adv && s1_emits) begin
         em_query_ff <= (s1_kind_ff == gqvg_pkg::REQ_QUERY);
         em_len_ff   <= adv_total_ff;
         em_xl_ff    <= pen_x_ff;
         em_xr_ff    <= pen_x_ff + 16'(glyph_rd_ff.width);
         em_yt_ff    <= line_top_ff;
         em_yb_ff    <= line_top_ff - 16'(font_height_ff);
         em_lu_ff    <= glyph_rd_ff.left_u;
         em_ru_ff    <= glyph_rd_ff.right_u;
      end
   end

   // Select the current vertex
   logic        vtx_right;
   logic        vtx_bottom;
   logic [15:0] out_x;
   logic [15:0] out_y;
   logic [15:0] out_u;
   logic        out_v;
   logic [15:0] out_len;

   assign vtx_right  = gqvg_pkg::VTX_RIGHT_MASK[em_cnt_ff];
   assign vtx_bottom = gqvg_pkg::VTX_BOTTOM_MASK[em_cnt_ff];

   always_comb begin
      if (em_query_ff) begin
         out_x   = 16'd0;
         out_y   = 16'd0;
         out_u   = 16'd0;
         out_v   = 1'b0;
         out_len = em_len_ff;
      end else begin
         out_x   = vtx_right  ? em_xr_ff : em_xl_ff;
         out_y   = vtx_bottom ? em_yb_ff : em_yt_ff;
         out_u   = vtx_right  ? em_ru_ff : em_lu_ff;
         out_v   = vtx_bottom;
         out_len = 16'd0;
      end
   end

   assign rsp_tvalid = em_valid_ff;
   assign rsp_tlast  = em_last;
   assign rsp_tdata  = {7'd0, out_len, out_v, out_u, out_y, out_x};

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      em_cnt_ff <= gqvg_pkg::VTX_LAST)
      else $error("vertex counter past last vertex");

   a_query_single: assert property (@(posedge clock) disable iff (reset)
      (em_valid_ff && em_query_ff) |-> (em_cnt_ff == 3'd0))
      else $error("query result stepped beyond one transaction");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!s1_valid_ff && !em_valid_ff))
      else $error("pipeline not empty after reset");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emits && em_valid_ff) |-> rsp_done)
      else $error("new result loaded over an unfinished transaction");

endmodule
